// ----- hdl/tks_pkg.sv -----
`default_nettype none

package tks_pkg;

   localparam int NODE_COUNT    = 256;
   localparam int ALPHABET_SIZE = 256;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int CHAR_W        = $clog2(ALPHABET_SIZE);
   localparam int ADDR_W        = NODE_W + CHAR_W;
   localparam int TABLE_DEPTH   = NODE_COUNT * ALPHABET_SIZE;
   localparam int ENTRY_W       = NODE_W + 1;
   localparam int USED_W        = NODE_W + 1;
   localparam int CNT_W         = 16;
   localparam int MATCH_NODE_W  = 8;

   localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
   localparam logic [CHAR_W-1:0] END_LOOKAHEAD = 8'h20;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_SCAN   = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_MATCH    = 2'd0,
      KIND_DONE     = 2'd1,
      KIND_OVERFLOW = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_ROOT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      req_kind_type      op;
      logic [CHAR_W-1:0] chr;
      logic              alnum;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic              fin;
      logic [NODE_W-1:0] node;
   } entry_type;

   typedef struct packed {
      result_kind_type         kind;
      logic [MATCH_NODE_W-1:0] node;
      logic [CNT_W-1:0]        total;
      logic                    last;
   } rsp_type;

   function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
             (c >= 8'h41 && c <= 8'h5a);
   endfunction

endpackage

`default_nettype wire

// ----- hdl/tks_ram.sv -----
`default_nettype none

module tks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hdl/tks_front.sv -----
`default_nettype none

module tks_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   output logic                           full,
   input  wire logic                      req_type,
   input  wire logic [7:0]                req_char_byte,
   input  wire logic                      req_end_flag,
   input  wire logic                      clearing,
   output tks_pkg::cmd_type               cmd,
   output logic                           cmd_valid,
   input  wire logic                      cmd_pop
);

   import tks_pkg::*;

   cmd_type              new_cmd;
   cmd_type              q_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   // classify the incoming transaction
   always_comb begin
      new_cmd.op    = req_kind_type'(req_type);
      new_cmd.chr   = fold(req_char_byte);
      new_cmd.alnum = is_alnum(req_char_byte);
      new_cmd.last  = req_end_flag;
   end

   assign full      = (count_ff == CMD_CNT_W'(CMD_DEPTH)) || clearing;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tks_engine.sv -----
`default_nettype none

module tks_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tks_pkg::cmd_type cmd,
   input  wire logic             cmd_valid,
   output logic                  cmd_pop,
   output logic                  clearing,
   output logic                  rsp_push,
   output tks_pkg::rsp_type      rsp,
   input  wire logic             rsp_full
);

   import tks_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   cmd_type           cmd_ff, cmd_in;
   logic [NODE_W-1:0] look_ff, look_in;
   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [NODE_W-1:0] scan_node_ff, scan_node_in;
   logic              m1_ff, m1_in;
   logic              pending_ff, pending_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [USED_W-1:0] used_ff, used_in;
   rsp_type           slot_ff [3];
   rsp_type           slot_in [3];
   logic [2:0]        vld_ff, vld_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   entry_type         ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   entry_type         hit;
   logic [NODE_W-1:0] look_idle;
   logic              ins_hit;
   logic              store_full;
   logic              need_root;
   logic              m2;
   logic              scan_any;
   logic              do_finish;
   logic [CNT_W:0]    cnt_sum;
   logic [CNT_W-1:0]  cnt_sat;
   logic [1:0]        sel;
   logic              emit_last;

   tks_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_child_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // each child entry also carries the final mark of the node it points to
   always_comb begin
      hit        = entry_type'(ram_rdata);
      look_idle  = cursor_ff;
      if (cmd.op == REQ_SCAN) begin
         look_idle = (pending_ff && !cmd.alnum) ? '0 : scan_node_ff;
      end
      ins_hit    = (hit.node != '0);
      store_full = (used_ff == USED_W'(NODE_COUNT));
      need_root  = (cmd_ff.op == REQ_SCAN) && !ins_hit && (look_ff != '0);
      m2         = hit.fin && cmd_ff.last && !is_alnum(END_LOOKAHEAD);
      scan_any   = m1_ff || cmd_ff.last;
      do_finish  = ((state_ff == ST_EXEC) && (cmd_ff.op == REQ_SCAN) && !need_root) ||
                   (state_ff == ST_ROOT);
      cnt_sum    = {1'b0, count_ff} + (CNT_W+1)'(m1_ff) + (CNT_W+1)'(m2);
      cnt_sat    = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];
      if (vld_ff[0]) begin
         sel       = 2'd0;
         emit_last = !(vld_ff[1] || vld_ff[2]);
      end else if (vld_ff[1]) begin
         sel       = 2'd1;
         emit_last = !vld_ff[2];
      end else begin
         sel       = 2'd2;
         emit_last = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd_ff.op == REQ_INSERT) begin
               state_in = (!ins_hit && store_full) ? ST_EMIT : ST_IDLE;
            end else if (need_root) begin
               state_in = ST_ROOT;
            end else begin
               state_in = scan_any ? ST_EMIT : ST_IDLE;
            end
         end
         ST_ROOT: begin
            state_in = scan_any ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_full && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      look_in      = look_ff;
      cursor_in    = cursor_ff;
      scan_node_in = scan_node_ff;
      m1_in        = m1_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      slot_in      = slot_ff;
      vld_in       = vld_ff;
      ram_we       = 1'b0;
      ram_waddr    = {look_ff, cmd_ff.chr};
      ram_wdata    = '0;
      ram_raddr    = {look_idle, cmd.chr};
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      clearing     = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            cmd_pop = cmd_valid;
            cmd_in  = cmd;
            look_in = look_idle;
            m1_in   = (cmd.op == REQ_SCAN) && pending_ff && !cmd.alnum;
         end
         ST_EXEC: begin
            if (cmd_ff.op == REQ_INSERT) begin
               if (ins_hit) begin
                  cursor_in = cmd_ff.last ? '0 : hit.node;
                  if (cmd_ff.last) begin
                     ram_we    = 1'b1;
                     ram_wdata = '{fin: 1'b1, node: hit.node};
                  end
               end else if (store_full) begin
                  slot_in[0] = '{kind: KIND_OVERFLOW, node: '0, total: '0, last: 1'b0};
                  vld_in     = 3'b001;
                  if (cmd_ff.last) begin
                     cursor_in = '0;
                  end
               end else begin
                  ram_we    = 1'b1;
                  ram_wdata = '{fin: cmd_ff.last, node: used_ff[NODE_W-1:0]};
                  used_in   = used_ff + 1'b1;
                  cursor_in = cmd_ff.last ? '0 : used_ff[NODE_W-1:0];
               end
            end else if (need_root) begin
               ram_raddr = {{NODE_W{1'b0}}, cmd_ff.chr};
            end
         end
         ST_EMIT: begin
            rsp_push = !rsp_full;
            if (!rsp_full) begin
               vld_in[sel] = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (do_finish) begin
         pending_in   = hit.fin && !cmd_ff.last;
         scan_node_in = cmd_ff.last ? '0 : hit.node;
         count_in     = cmd_ff.last ? '0 : cnt_sat;
         slot_in[0]   = '{kind: KIND_MATCH, node: MATCH_NODE_W'(scan_node_ff),
                          total: '0, last: 1'b0};
         slot_in[1]   = '{kind: KIND_MATCH, node: MATCH_NODE_W'(hit.node),
                          total: '0, last: 1'b0};
         slot_in[2]   = '{kind: KIND_DONE, node: '0, total: cnt_sat, last: 1'b0};
         vld_in       = {cmd_ff.last, m2, m1_ff};
      end
   end

   always_comb begin
      rsp      = slot_ff[sel];
      rsp.last = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         cursor_ff    <= '0;
         scan_node_ff <= '0;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         used_ff      <= USED_W'(1);
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cursor_ff    <= cursor_in;
         scan_node_ff <= scan_node_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         vld_ff       <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      look_ff <= look_in;
      m1_ff   <= m1_in;
      slot_ff <= slot_in;
   end

   a_cursor_exists: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_ff} < used_ff)
      else $error("insert cursor points past the allocated nodes");

   a_scan_exists: assert property (@(posedge clock) disable iff (reset)
      {1'b0, scan_node_ff} < used_ff)
      else $error("scan node points past the allocated nodes");

   a_pending_not_root: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> (scan_node_ff != '0))
      else $error("pending match held on the root");

   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (vld_ff != '0))
      else $error("emit state with no result waiting");

   a_pop_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff == ST_EXEC))
      else $error("popped transaction not executed");

endmodule

`default_nettype wire

// ----- hdl/tks_rsp_queue.sv -----
`default_nettype none

module tks_rsp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rsp_push,
   input  wire tks_pkg::rsp_type rsp,
   output logic                  rsp_full,
   output logic                  empty,
   input  wire logic             pop,
   output tks_pkg::rsp_type      head
);

   import tks_pkg::*;

   rsp_type              q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign rsp_full = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign empty    = (count_ff == '0);
   assign head     = q_ff[rd_ptr_ff];
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= rsp;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/trie_keyword_scanner_core.sv -----
// flow: each transaction is taken from the command queue, then the child table is read, then updated;
//    a scan byte that misses away from the root takes a second read at the root before the update
// results: the engine pushes them into the result queue one per cycle while it is not full, and
//    takes the next transaction only when all results of the last one are pushed
// reset: synchronous, clears queues and scanner state, then the child table is swept to zero,
//    one entry per cycle for all NODE_COUNT * 256 = 65536 entries, while full stays high
`default_nettype none

module trie_keyword_scanner_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic       req_type,
   input  wire logic [7:0] req_char_byte,
   input  wire logic       req_end_flag,
   output logic            empty,
   input  wire logic       pop,
   output logic [1:0]      rsp_result_kind,
   output logic [7:0]      rsp_match_node,
   output logic [15:0]     rsp_threat_total,
   output logic            rsp_last_result
);

   import tks_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    clearing;
   logic    rsp_push;
   rsp_type rsp;
   logic    rsp_full;
   rsp_type head;

   tks_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_type     (req_type),
      .req_char_byte(req_char_byte),
      .req_end_flag (req_end_flag),
      .clearing     (clearing),
      .cmd          (cmd),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop)
   );

   tks_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .clearing (clearing),
      .rsp_push (rsp_push),
      .rsp      (rsp),
      .rsp_full (rsp_full)
   );

   tks_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .rsp_push(rsp_push),
      .rsp     (rsp),
      .rsp_full(rsp_full),
      .empty   (empty),
      .pop     (pop),
      .head    (head)
   );

   assign rsp_result_kind  = head.kind;
   assign rsp_match_node   = head.node;
   assign rsp_threat_total = head.total;
   assign rsp_last_result  = head.last;

endmodule

`default_nettype wire
